// ===== src/tvs_pkg.sv =====
// Shared types, constants and helpers for the trilinear volume sampler.
`default_nettype none
package tvs_pkg;

    localparam int MAX_DIM     = 64;
    localparam int FRAC_BITS   = 8;
    localparam int DIM_W       = $clog2(MAX_DIM) + 1;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int ADDR_W      = 3 * IDX_W;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int DXY_W       = 2 * IDX_W + 1;
    localparam int COORD_W     = 14;
    localparam int WF_W        = FRAC_BITS + 1;
    localparam int PW_W        = 2 * FRAC_BITS + 1;
    localparam int W_W         = 3 * FRAC_BITS + 1;
    localparam int PROD_W      = W_W + 8;
    localparam int SUM_W       = PROD_W + 3;
    localparam int VAL_W       = 16;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int ODEPTH      = 4;
    localparam int OPTR_W      = $clog2(ODEPTH);
    localparam int OCNT_W      = OPTR_W + 1;
    localparam int NBR         = 8;

    localparam logic [1:0] CFG_DIM_X = 2'd0;
    localparam logic [1:0] CFG_DIM_Y = 2'd1;
    localparam logic [1:0] CFG_DIM_Z = 2'd2;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // One request after classification and address generation.
    typedef struct packed {
        logic                       kind;
        logic [ADDR_W-1:0]          base;
        logic [7:0]                 wval;
        logic                       oor;
        logic                       sx;
        logic [DIM_W-1:0]           syoff;
        logic [DXY_W-1:0]           szoff;
        logic [WF_W-1:0]            fx;
        logic [WF_W-1:0]            gx;
        logic [3:0][PW_W-1:0]       pw;
    } t_job;

    // Clamp a dimension register into 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) r = DIM_W'(1);
        else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/tvs_front.sv =====
// Front end: accept requests, range-check and build addresses and pair weights.
`default_nettype none
module tvs_front import tvs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic               i_kind,
    input  wire logic [ADDR_W-1:0]  i_voxel_index,
    input  wire logic [7:0]         i_voxel_value,
    input  wire logic [COORD_W-1:0] i_coord_x,
    input  wire logic [COORD_W-1:0] i_coord_y,
    input  wire logic [COORD_W-1:0] i_coord_z,
    input  wire logic [DIM_W-1:0]   i_dim_x,
    input  wire logic [DIM_W-1:0]   i_dim_y,
    input  wire logic [DIM_W-1:0]   i_dim_z,
    output logic                    o_push,
    output t_job                    o_job
);

    logic                 r_v;
    logic                 r_kind;
    logic [ADDR_W-1:0]    r_idx;
    logic [7:0]           r_val;
    logic [IDX_W-1:0]     r_ix, r_iy, r_iz;
    logic [FRAC_BITS-1:0] r_fx, r_fy, r_fz;
    logic                 r_oor, r_sx, r_sy, r_sz;
    logic [DIM_W-1:0]     r_dx;
    logic [DXY_W-1:0]     r_dxy;

    logic [DIM_W-1:0]     dx, dy, dz;
    logic [IDX_W-1:0]     ix, iy, iz;
    logic [2*DIM_W-1:0]   dxy_full;
    logic [WF_W-1:0]      gy, gz, fy9, fz9;
    logic [ADDR_W+1:0]    base_full;

    assign dx = eff_dim(i_dim_x);
    assign dy = eff_dim(i_dim_y);
    assign dz = eff_dim(i_dim_z);
    assign ix = i_coord_x[FRAC_BITS +: IDX_W];
    assign iy = i_coord_y[FRAC_BITS +: IDX_W];
    assign iz = i_coord_z[FRAC_BITS +: IDX_W];
    assign dxy_full = dx * dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_accept;
        end
        if (i_accept) begin
            r_kind <= i_kind;
            r_idx  <= i_voxel_index;
            r_val  <= i_voxel_value;
            r_ix   <= ix;
            r_iy   <= iy;
            r_iz   <= iz;
            r_fx   <= i_coord_x[FRAC_BITS-1:0];
            r_fy   <= i_coord_y[FRAC_BITS-1:0];
            r_fz   <= i_coord_z[FRAC_BITS-1:0];
            // integer bits above the index width always mean out of range
            r_oor  <= ((COORD_W-FRAC_BITS+1)'(i_coord_x[COORD_W-1:FRAC_BITS])
                       >= (COORD_W-FRAC_BITS+1)'(dx))
                   || ((COORD_W-FRAC_BITS+1)'(i_coord_y[COORD_W-1:FRAC_BITS])
                       >= (COORD_W-FRAC_BITS+1)'(dy))
                   || ((COORD_W-FRAC_BITS+1)'(i_coord_z[COORD_W-1:FRAC_BITS])
                       >= (COORD_W-FRAC_BITS+1)'(dz));
            r_sx   <= (DIM_W'(ix) + DIM_W'(1)) < dx;
            r_sy   <= (DIM_W'(iy) + DIM_W'(1)) < dy;
            r_sz   <= (DIM_W'(iz) + DIM_W'(1)) < dz;
            r_dx   <= dx;
            r_dxy  <= dxy_full[DXY_W-1:0];
        end
    end

    assign fy9 = WF_W'(r_fy);
    assign fz9 = WF_W'(r_fz);
    assign gy  = WF_W'(1 << FRAC_BITS) - fy9;
    assign gz  = WF_W'(1 << FRAC_BITS) - fz9;
    assign base_full = (ADDR_W+2)'(r_iz * r_dxy) + (ADDR_W+2)'(r_iy * r_dx)
                     + (ADDR_W+2)'(r_ix);

    always_comb begin
        o_push      = r_v;
        o_job.kind  = r_kind;
        o_job.base  = (r_kind == KIND_WRITE) ? r_idx : base_full[ADDR_W-1:0];
        o_job.wval  = r_val;
        o_job.oor   = r_oor;
        o_job.sx    = r_sx;
        o_job.syoff = r_sy ? r_dx : '0;
        o_job.szoff = r_sz ? r_dxy : '0;
        o_job.fx    = WF_W'(r_fx);
        o_job.gx    = WF_W'(1 << FRAC_BITS) - WF_W'(r_fx);
        o_job.pw[0] = PW_W'(gy * gz);
        o_job.pw[1] = PW_W'(fy9 * gz);
        o_job.pw[2] = PW_W'(gy * fz9);
        o_job.pw[3] = PW_W'(fy9 * fz9);
    end

endmodule
`default_nettype wire

// ===== src/tvs_queue.sv =====
// Short request queue between the front end and the back end.
`default_nettype none
module tvs_queue import tvs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_job              i_job,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output t_job                   o_job,
    output logic [QCNT_W-1:0]      o_count
);

    t_job              r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QPTR_W'(1);
            if (i_pop)  r_rp <= r_rp + QPTR_W'(1);
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
        if (i_push) r_q[r_wp] <= i_job;
    end

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rp];
    assign o_count = r_cnt;

endmodule
`default_nettype wire

// ===== src/tvs_back.sv =====
// Back end: voxel store replicas, weighting, accumulation and result buffer.
`default_nettype none
module tvs_back import tvs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_job              i_q_job,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [VAL_W-1:0]       o_sample_value,
    output logic                   o_out_of_range
);

    logic [ADDR_W-1:0] addr [NBR];
    logic              pop, wr, rd;

    logic              r1_v, r1_oor;
    logic [W_W-1:0]    r1_w  [NBR];
    logic [7:0]        r1_rd [NBR];
    logic              r2_v, r2_oor;
    logic [PROD_W-1:0] r2_p  [NBR];

    logic [VAL_W-1:0]  r_ov [ODEPTH];
    logic              r_oo [ODEPTH];
    logic [OPTR_W-1:0] r_owp, r_orp;
    logic [OCNT_W-1:0] r_ocnt;
    logic [OCNT_W+1:0] pending;
    logic [SUM_W-1:0]  acc;
    logic [SUM_W-1:0]  rounded;
    logic              opop;

    // Hold the queue unless the results buffered and in flight leave a result slot free.
    assign pending = (OCNT_W+2)'(r_ocnt) + (OCNT_W+2)'(r1_v) + (OCNT_W+2)'(r2_v);
    assign pop = i_q_valid && (pending < (OCNT_W+2)'(ODEPTH));
    assign o_q_pop = pop;
    assign wr = pop && (i_q_job.kind == KIND_WRITE);
    assign rd = pop && (i_q_job.kind == KIND_SAMPLE);

    for (genvar n = 0; n < NBR; n++) begin : g_nbr
        logic [7:0]         r_mem [STORE_DEPTH];
        logic [W_W+WF_W-1:0] wfull;

        assign addr[n] = i_q_job.base
                       + (n[0] ? ADDR_W'(i_q_job.sx)    : '0)
                       + (n[1] ? ADDR_W'(i_q_job.syoff) : '0)
                       + (n[2] ? ADDR_W'(i_q_job.szoff) : '0);
        assign wfull = (n[0] ? i_q_job.fx : i_q_job.gx) * i_q_job.pw[n[2:1]];

        // each replica holds the whole volume so all corners read at once
        always_ff @(posedge i_clk) begin
            if (wr) r_mem[i_q_job.base] <= i_q_job.wval;
            if (rd) r1_rd[n] <= r_mem[addr[n]];
        end

        always_ff @(posedge i_clk) begin
            r1_w[n] <= wfull[W_W-1:0];
            r2_p[n] <= PROD_W'(r1_rd[n] * r1_w[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            r1_v <= rd;
            r2_v <= r1_v;
        end
        r1_oor <= i_q_job.oor;
        r2_oor <= r1_oor;
    end

    always_comb begin
        acc = '0;
        for (int n = 0; n < NBR; n++) acc = acc + SUM_W'(r2_p[n]);
        rounded = (acc + SUM_W'(1 << (2*FRAC_BITS-1))) >> (2*FRAC_BITS);
    end

    assign opop = (r_ocnt != '0) && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r2_v) r_owp <= r_owp + OPTR_W'(1);
            if (opop) r_orp <= r_orp + OPTR_W'(1);
            r_ocnt <= r_ocnt + OCNT_W'(r2_v) - OCNT_W'(opop);
        end
        if (r2_v) begin
            r_ov[r_owp] <= r2_oor ? '0 : rounded[VAL_W-1:0];
            r_oo[r_owp] <= r2_oor;
        end
    end

    assign o_valid        = (r_ocnt != '0);
    assign o_sample_value = r_ov[r_orp];
    assign o_out_of_range = r_oo[r_orp];

endmodule
`default_nettype wire

// ===== src/trilinear_volume_sampler.sv =====
// Top level of the trilinear volume sampler: config registers, front, queue, back.
//
//  channel   direction  handshake          payload
//  request   in         i_valid / o_stall  i_kind, i_voxel_index, i_voxel_value, i_coord_x/y/z
//  result    out        o_valid / i_stall  o_sample_value, o_out_of_range
//  config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One request per cycle sustained while o_stall is low. A sample result passes through
// the front register, the queue, the voxel read of the eight store replicas, the
// weight multiply and the final sum into the result buffer. Writes give no
// result. Reset (synchronous, active low) empties the pipeline and sets all
// dimensions to 64; the voxel store holds garbage until written. The front
// stalls only when the four-entry queue could overflow; the back holds the
// queue while its four-entry result buffer could overflow.
`default_nettype none
module trilinear_volume_sampler import tvs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_kind,
    input  wire logic [ADDR_W-1:0]  i_voxel_index,
    input  wire logic [7:0]         i_voxel_value,
    input  wire logic [COORD_W-1:0] i_coord_x,
    input  wire logic [COORD_W-1:0] i_coord_y,
    input  wire logic [COORD_W-1:0] i_coord_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [VAL_W-1:0]        o_sample_value,
    output logic                    o_out_of_range,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [DIM_W-1:0]   i_cfg_data
);

    logic [DIM_W-1:0]  r_dim_x, r_dim_y, r_dim_z;
    logic              accept, push, q_valid, q_pop;
    t_job              f_job, q_job;
    logic [QCNT_W-1:0] q_count;
    logic [QCNT_W:0]   in_flight;

    // Dimension registers: indexes past the list drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x <= DIM_W'(MAX_DIM);
            r_dim_y <= DIM_W'(MAX_DIM);
            r_dim_z <= DIM_W'(MAX_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIM_X: r_dim_x <= i_cfg_data;
                CFG_DIM_Y: r_dim_y <= i_cfg_data;
                CFG_DIM_Z: r_dim_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stall while the queue plus the request in the front register could fill it.
    assign in_flight = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(push);
    assign o_stall   = (in_flight >= (QCNT_W+1)'(QDEPTH));
    assign accept    = i_valid && !o_stall;

    tvs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_kind        (i_kind),
        .i_voxel_index (i_voxel_index),
        .i_voxel_value (i_voxel_value),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_dim_x       (r_dim_x),
        .i_dim_y       (r_dim_y),
        .i_dim_z       (r_dim_z),
        .o_push        (push),
        .o_job         (f_job)
    );

    tvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_count)
    );

    tvs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_job        (q_job),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_sample_value (o_sample_value),
        .o_out_of_range (o_out_of_range)
    );

endmodule
`default_nettype wire

// ===== test/tb_trilinear_volume_sampler.sv =====
// Self-checking testbench for the trilinear volume sampler.
`timescale 1ns / 1ps
`default_nettype none
module tb_trilinear_volume_sampler;
    import tvs_pkg::*;

    // Register index past the end of the register list; writes to it are dropped.
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         ONE_W      = 1 << FRAC_BITS;
    localparam int         HOLD_LEN   = 200;
    localparam int         CYCLE_CAP  = 600000;
    localparam int         DRAIN_LEN  = 20;

    typedef struct {
        logic [VAL_W-1:0] value;
        logic             oor;
    } t_sample;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_kind = KIND_WRITE;
    logic [ADDR_W-1:0]  i_voxel_index = '0;
    logic [7:0]         i_voxel_value = '0;
    logic [COORD_W-1:0] i_coord_x = '0;
    logic [COORD_W-1:0] i_coord_y = '0;
    logic [COORD_W-1:0] i_coord_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [VAL_W-1:0]   o_sample_value;
    logic               o_out_of_range;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [DIM_W-1:0]   i_cfg_data = '0;

    trilinear_volume_sampler uut (.*);

    // Shadow copy of the volume, which voxels hold defined data, and the dimensions.
    logic [7:0]       vol_shadow [STORE_DEPTH];
    bit               vol_written [STORE_DEPTH];
    logic [DIM_W-1:0] dim_reg [3];

    t_sample pending_samples[$];
    int      fail_count;
    int      cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_left;
    bit      hold_req;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result-side stall: random idling, or a long hold-off when requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_LEN;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        fail_count++;
    endtask

    // Compare each accepted result with the oldest expected sample.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected result", o_sample_value, -1);
            end else begin
                t_sample want;
                want = pending_samples.pop_front();
                if (o_sample_value !== want.value)
                    report_mismatch("sample_value", o_sample_value, want.value);
                if (o_out_of_range !== want.oor)
                    report_mismatch("out_of_range", o_out_of_range, want.oor);
            end
        end
    end

    function automatic int clamp_dim(input logic [DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return d;
    endfunction

    // Eight neighbor addresses: bit0 steps x, bit1 steps y, bit2 steps z.
    function automatic void corner_addrs(input logic [COORD_W-1:0] cx, cy, cz,
                                         output int addr [8], output bit oor);
        int dx, dy, dz, ix, iy, iz, base, sx, sy, sz;
        dx = clamp_dim(dim_reg[0]);
        dy = clamp_dim(dim_reg[1]);
        dz = clamp_dim(dim_reg[2]);
        ix = cx >> FRAC_BITS;
        iy = cy >> FRAC_BITS;
        iz = cz >> FRAC_BITS;
        oor = (ix > dx - 1) || (iy > dy - 1) || (iz > dz - 1);
        base = iz * dx * dy + iy * dx + ix;
        sx = (ix < dx - 1) ? 1 : 0;
        sy = (iy < dy - 1) ? dx : 0;
        sz = (iz < dz - 1) ? dx * dy : 0;
        for (int k = 0; k < 8; k++)
            addr[k] = base + (k[0] ? sx : 0) + (k[1] ? sy : 0) + (k[2] ? sz : 0);
    endfunction

    function automatic t_sample predict_sample(input logic [COORD_W-1:0] cx, cy, cz);
        int              addr [8];
        bit              oor;
        longint unsigned acc, wx, wy, wz;
        t_sample         r;
        corner_addrs(cx, cy, cz, addr, oor);
        if (oor) begin
            r.value = '0;
            r.oor   = 1'b1;
            return r;
        end
        acc = 0;
        for (int k = 0; k < 8; k++) begin
            wx = k[0] ? (cx % ONE_W) : ONE_W - (cx % ONE_W);
            wy = k[1] ? (cy % ONE_W) : ONE_W - (cy % ONE_W);
            wz = k[2] ? (cz % ONE_W) : ONE_W - (cz % ONE_W);
            acc += vol_shadow[addr[k]] * wx * wy * wz;
        end
        acc = (acc + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        r.value = acc[VAL_W-1:0];
        r.oor   = 1'b0;
        return r;
    endfunction

    // Offer one request, hold it until taken, update the shadow, then maybe idle.
    task automatic send_request(input logic kind, input logic [ADDR_W-1:0] idx,
                                input logic [7:0] val, input logic [COORD_W-1:0] cx, cy, cz);
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_voxel_index <= idx;
        i_voxel_value <= val;
        i_coord_x     <= cx;
        i_coord_y     <= cy;
        i_coord_z     <= cz;
        do @(posedge i_clk); while (o_stall);
        if (kind == KIND_WRITE) begin
            vol_shadow[idx]  = val;
            vol_written[idx] = 1'b1;
        end else begin
            pending_samples.push_back(predict_sample(cx, cy, cz));
        end
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Fill any neighbor that holds no data yet, then issue the sample request.
    task automatic send_sample(input logic [COORD_W-1:0] cx, cy, cz);
        int addr [8];
        bit oor;
        corner_addrs(cx, cy, cz, addr, oor);
        if (!oor) begin
            for (int k = 0; k < 8; k++)
                if (!vol_written[addr[k]])
                    send_request(KIND_WRITE, ADDR_W'(addr[k]), 8'($urandom_range(255)),
                                 '0, '0, '0);
        end
        send_request(KIND_SAMPLE, ADDR_W'($urandom), 8'($urandom), cx, cy, cz);
    endtask

    task automatic drop_valid();
        if (i_valid) i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for the pipeline to empty before touching a register.
    task automatic wait_idle();
        drop_valid();
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx != CFG_UNUSED) dim_reg[idx] = data;
        @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] dx, dy, dz);
        wait_idle();
        write_reg(CFG_DIM_X, dx);
        write_reg(CFG_DIM_Y, dy);
        write_reg(CFG_DIM_Z, dz);
    endtask

    // Pick a coordinate on one axis: mostly in range, with edge fractions often.
    function automatic logic [COORD_W-1:0] pick_coord(input int d, input bit beyond);
        int ipart, fpart;
        ipart = (beyond && d < MAX_DIM) ? $urandom_range(MAX_DIM - 1, d) : $urandom_range(d - 1);
        case ($urandom_range(3))
            0:       fpart = 0;
            1:       fpart = ONE_W - 1;
            default: fpart = $urandom_range(ONE_W - 1);
        endcase
        return COORD_W'(ipart * ONE_W + fpart);
    endfunction

    // Corners of the full-size volume, extreme fractions and voxel bytes.
    task automatic test_directed_full_volume();
        send_request(KIND_WRITE, '0, 8'd0, '1, '1, '1);
        send_request(KIND_WRITE, '1, 8'd255, '0, '0, '0);
        send_sample('0, '0, '0);
        send_sample('1, '1, '1);
        send_sample(14'h3F80, 14'h00FF, 14'h2A55);
        send_sample(14'h00FF, 14'h3FFF, 14'h0000);
        send_sample(14'h1D01, 14'h1555, 14'h3F00);
    endtask

    // Small volumes, out-of-range samples on each axis, clamped and dropped registers.
    task automatic test_directed_dims();
        set_dims(7'd4, 7'd3, 7'd2);
        send_sample(14'h0380, 14'h0280, 14'h0180);
        send_sample(14'h0400, 14'h0000, 14'h0000);
        send_sample(14'h0000, 14'h0300, 14'h0000);
        send_sample(14'h0000, 14'h0000, 14'h0200);
        send_sample(14'h3FFF, 14'h3FFF, 14'h3FFF);
        set_dims(7'd0, 7'd127, 7'd1);
        send_sample(14'h0000, 14'h3FFF, 14'h00FF);
        send_sample(14'h0100, 14'h2080, 14'h0000);
        wait_idle();
        write_reg(CFG_UNUSED, 7'd2);
        send_sample(14'h0040, 14'h3F40, 14'h0010);
        set_dims(7'd1, 7'd1, 7'd1);
        send_sample(14'h00FF, 14'h0080, 14'h0001);
        send_sample(14'h0100, 14'h0000, 14'h0000);
    endtask

    // Random traffic over a handful of volume shapes, mostly small.
    task automatic test_random_traffic(input int n_items);
        int dx, dy, dz;
        for (int s = 0; s < 4; s++) begin
            case (s)
                0:       set_dims(7'd64, DIM_W'($urandom_range(1, 4)),
                                  DIM_W'($urandom_range(1, 4)));
                1:       set_dims(DIM_W'($urandom_range(1, 3)), DIM_W'($urandom_range(1, 3)),
                                  7'd64);
                default: set_dims(DIM_W'($urandom_range(0, 9)), DIM_W'($urandom_range(0, 9)),
                                  DIM_W'($urandom_range(0, 9)));
            endcase
            dx = clamp_dim(dim_reg[0]);
            dy = clamp_dim(dim_reg[1]);
            dz = clamp_dim(dim_reg[2]);
            for (int n = 0; n < n_items / 4; n++) begin
                case ($urandom_range(9))
                    0:       send_request(KIND_WRITE, ADDR_W'($urandom), 8'($urandom),
                                          COORD_W'($urandom), COORD_W'($urandom),
                                          COORD_W'($urandom));
                    1:       send_request(KIND_WRITE, ADDR_W'($urandom_range(dx * dy * dz - 1)),
                                          8'($urandom), COORD_W'($urandom),
                                          COORD_W'($urandom), COORD_W'($urandom));
                    2:       send_sample(pick_coord(dx, 1'($urandom_range(1))),
                                         pick_coord(dy, 1'($urandom_range(1))),
                                         pick_coord(dz, 1'($urandom_range(1))));
                    default: send_sample(pick_coord(dx, 0), pick_coord(dy, 0), pick_coord(dz, 0));
                endcase
            end
        end
    endtask

    // Hold the result side off while samples keep coming so the input stalls.
    task automatic test_backpressure();
        set_dims(7'd5, 7'd5, 7'd5);
        @(negedge i_clk) hold_req = 1'b1;
        @(posedge i_clk);
        for (int n = 0; n < 40; n++)
            send_sample(pick_coord(5, 0), pick_coord(5, 0), pick_coord(5, 0));
    endtask

    initial begin
        fail_count    = 0;
        cycle_count   = 0;
        hold_left     = 0;
        hold_req      = 1'b0;
        send_idle_pct = 19;
        recv_idle_pct = 66;
        for (int k = 0; k < 3; k++) dim_reg[k] = 7'd64;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_full_volume();
        test_directed_dims();
        test_random_traffic(320);
        test_backpressure();

        wait_idle();
        send_idle_pct = 66;
        recv_idle_pct = 19;
        test_random_traffic(320);

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(320);
        test_backpressure();

        wait_idle();
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
